@@ rtl/core/pade_pkg.sv @@
// shared constants, codes and control types of the packed array delete engine
`default_nettype none

package pade_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int CMD_W     = 3;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 6;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 3'd0,
    CMD_DEL_FIRST = 3'd1,
    CMD_DEL_LAST  = 3'd2,
    CMD_DEL_POS   = 3'd3,
    CMD_DEL_VAL   = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PTR_HOLD = 3'd0,
    PTR_ZERO = 3'd1,
    PTR_LAST = 3'd2,
    PTR_POS  = 3'd3,
    PTR_INC  = 3'd4
  } ptr_sel_t;

  typedef enum logic [1:0] {
    RD_PTR  = 2'd0,
    RD_PTR1 = 2'd1,
    RD_PTR2 = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     append;
    ptr_sel_t ptr_sel;
    rd_sel_t  rd_sel;
    logic     capture;
    logic     shift_write;
    logic     dec_count;
    logic     status_we;
    status_t  status_code;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             full;
    logic             empty;
    logic             pos_bad;
    logic             match;
    logic             last;
    logic             more;
    logic             out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/pade_if.sv @@
// request and response channel interfaces
`default_nettype none

interface pade_req_if;
  logic                              valid;
  logic                              ready;
  logic [pade_pkg::CMD_W-1:0]        command;
  logic signed [pade_pkg::WORD_W-1:0] value;
  logic [pade_pkg::POS_W-1:0]        position;

  modport source (output valid, command, value, position, input ready);
  modport sink (input valid, command, value, position, output ready);
endinterface

interface pade_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [pade_pkg::STATUS_W-1:0]      status;
  logic signed [pade_pkg::WORD_W-1:0] removed_word;
  logic [pade_pkg::COUNT_W-1:0]       entry_count;

  modport source (output valid, status, removed_word, entry_count, input ready);
  modport sink (input valid, status, removed_word, entry_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pade_ctrl.sv @@
// command sequencer for append, scan and shift
`default_nettype none

module pade_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire pade_pkg::dp_sts_t sts,
  output pade_pkg::dp_cmd_t      cmd
);
  import pade_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DECODE  = 7'b0000010,
    S_FETCH   = 7'b0000100,
    S_SCAN    = 7'b0001000,
    S_CAPTURE = 7'b0010000,
    S_MOVE    = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.ptr_sel     = PTR_HOLD;
    cmd.rd_sel      = RD_PTR;
    cmd.status_code = ST_OK;
    state_next      = state;
    req_ready       = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        priority if (sts.item_cmd == CMD_APPEND) begin
          if (sts.full) begin
            cmd.status_we   = 1'b1;
            cmd.status_code = ST_FULL;
          end else begin
            cmd.append = 1'b1;
          end
        end else if (sts.item_cmd > CMD_DEL_VAL) begin
          state_next = S_FINISH;
        end else if (sts.empty) begin
          cmd.status_we   = 1'b1;
          cmd.status_code = ST_EMPTY;
        end else if (sts.item_cmd == CMD_DEL_FIRST) begin
          cmd.ptr_sel = PTR_ZERO;
          state_next  = S_FETCH;
        end else if (sts.item_cmd == CMD_DEL_LAST) begin
          cmd.ptr_sel = PTR_LAST;
          state_next  = S_FETCH;
        end else if (sts.item_cmd == CMD_DEL_POS) begin
          if (sts.pos_bad) begin
            cmd.status_we   = 1'b1;
            cmd.status_code = ST_RANGE;
          end else begin
            cmd.ptr_sel = PTR_POS;
            state_next  = S_FETCH;
          end
        end else begin
          cmd.ptr_sel = PTR_ZERO;
          state_next  = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.rd_sel = RD_PTR;
        state_next = (sts.item_cmd == CMD_DEL_VAL) ? S_SCAN : S_CAPTURE;
      end
      S_SCAN: begin
        priority if (sts.match) begin
          cmd.capture = 1'b1;
          if (sts.last) begin
            cmd.dec_count = 1'b1;
            state_next    = S_FINISH;
          end else begin
            cmd.rd_sel = RD_PTR1;
            state_next = S_MOVE;
          end
        end else if (sts.last) begin
          cmd.status_we   = 1'b1;
          cmd.status_code = ST_NOTFOUND;
          state_next      = S_FINISH;
        end else begin
          cmd.ptr_sel = PTR_INC;
          cmd.rd_sel  = RD_PTR1;
        end
      end
      S_CAPTURE: begin
        cmd.capture = 1'b1;
        if (sts.last) begin
          cmd.dec_count = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.rd_sel = RD_PTR1;
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd.shift_write = 1'b1;
        cmd.ptr_sel     = PTR_INC;
        if (sts.more) begin
          cmd.rd_sel = RD_PTR2;
        end else begin
          cmd.dec_count = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/pade_dp.sv @@
// word store, count, pointer, item and result registers
`default_nettype none

module pade_dp #(
  parameter int DEPTH = pade_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire pade_pkg::dp_cmd_t                   cmd,
  output pade_pkg::dp_sts_t                        sts,
  input  wire logic [pade_pkg::CMD_W-1:0]          req_command,
  input  wire logic signed [pade_pkg::WORD_W-1:0]  req_value,
  input  wire logic [pade_pkg::POS_W-1:0]          req_position,
  input  wire logic                                rsp_ready,
  output logic                                     rsp_valid,
  output logic [pade_pkg::STATUS_W-1:0]            rsp_status,
  output logic signed [pade_pkg::WORD_W-1:0]       rsp_removed_word,
  output logic [pade_pkg::COUNT_W-1:0]             rsp_entry_count
);
  import pade_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int EXT_W  = CNT_W + 1;

  logic [WORD_W-1:0] mem [DEPTH];

  logic [CMD_W-1:0]  item_cmd;
  logic [WORD_W-1:0] item_value;
  logic [POS_W-1:0]  item_pos;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] ptr_next;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] removed;
  status_t           status;

  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              wr_en;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PTR:  rd_addr = ptr;
      RD_PTR1: rd_addr = ptr + ADDR_W'(1);
      RD_PTR2: rd_addr = ptr + ADDR_W'(2);
      default: rd_addr = ptr;
    endcase
  end

  assign wr_en   = cmd.append | cmd.shift_write;
  assign wr_addr = cmd.append ? count[ADDR_W-1:0] : ptr;
  assign wr_data = cmd.append ? item_value : rdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    unique case (cmd.ptr_sel)
      PTR_HOLD: ptr_next = ptr;
      PTR_ZERO: ptr_next = '0;
      PTR_LAST: ptr_next = ADDR_W'(count - CNT_W'(1));
      PTR_POS:  ptr_next = ADDR_W'(item_pos);
      PTR_INC:  ptr_next = ptr + ADDR_W'(1);
      default:  ptr_next = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (cmd.load_item) begin
      item_cmd   <= req_command;
      item_value <= req_value;
      item_pos   <= req_position;
    end
    if (cmd.load_item) begin
      removed <= '0;
    end else if (cmd.capture) begin
      removed <= rdata;
    end
    if (cmd.load_item) begin
      status <= ST_OK;
    end else if (cmd.status_we) begin
      status <= cmd.status_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + CNT_W'(1);
    end else if (cmd.dec_count) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_status       <= status;
      rsp_removed_word <= removed;
      rsp_entry_count  <= COUNT_W'(count);
    end
  end

  assign sts.item_cmd = item_cmd;
  assign sts.full     = (count == CNT_W'(DEPTH));
  assign sts.empty    = (count == '0);
  assign sts.pos_bad  = (32'(item_pos) >= 32'(count));
  assign sts.match    = (rdata == item_value);
  assign sts.last     = ((EXT_W'(ptr) + EXT_W'(1)) >= EXT_W'(count));
  assign sts.more     = ((EXT_W'(ptr) + EXT_W'(2)) < EXT_W'(count));
  assign sts.out_free = ~rsp_valid | rsp_ready;

endmodule

`default_nettype wire

@@ rtl/core/packed_array_delete_engine.sv @@
// packed array append and delete engine, top level
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    command, value, position
//  rsp      out  valid/ready    status, removed_word, entry_count
//
// append and rejected commands go from decode straight to the finish state
// a delete fetches and captures the entry, then shifts each later entry
// down one place; a delete by value first scans from index 0 for the
// match, all over the single read, single write word store
// reset clears the count, the result valid flag and the sequencer state; the word store is not cleared
// a result waits in the output register while the next item is taken;
// the next result holds the engine until that register is free

`default_nettype none

module packed_array_delete_engine #(
  parameter int DEPTH = pade_pkg::DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  pade_req_if.sink  req,
  pade_rsp_if.source rsp
);
  import pade_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    ready;

  pade_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  pade_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (dp_cmd),
    .sts              (dp_sts),
    .req_command      (req.command),
    .req_value        (req.value),
    .req_position     (req.position),
    .rsp_ready        (rsp.ready),
    .rsp_valid        (rsp.valid),
    .rsp_status       (rsp.status),
    .rsp_removed_word (rsp.removed_word),
    .rsp_entry_count  (rsp.entry_count)
  );

  assign req.ready = ready;

  a_dec_nonempty: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.dec_count |-> !dp_sts.empty)
    else $error("removal from an empty array");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.out_load |-> dp_sts.out_free)
    else $error("result overwrites one not yet taken");

  a_shift_inside: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.shift_write |-> !dp_sts.last)
    else $error("shift beyond the last valid entry");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second transfer while an item is in progress");

endmodule

`default_nettype wire

@@ verif/packed_array_delete_engine_tb.sv @@
// self-checking testbench of the packed array delete engine: directed rows, fill, random traffic
`default_nettype none

module packed_array_delete_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pade_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 16;
  localparam int CALM_FROM    = 700;
  localparam int CALM_TO      = 900;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   removed;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0]  pos;
    bit                typed;
    outcome_t          want;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 23;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_DEL_FIRST, 32'h0000_0000, 6'd0,  1'b1, '{ST_EMPTY,    32'h0, 7'd0}},
    '{CMD_DEL_LAST,  32'h0000_0000, 6'd0,  1'b1, '{ST_EMPTY,    32'h0, 7'd0}},
    '{CMD_DEL_POS,   32'h0000_0000, 6'd0,  1'b1, '{ST_EMPTY,    32'h0, 7'd0}},
    '{CMD_DEL_POS,   32'h0000_0000, 6'd63, 1'b1, '{ST_EMPTY,    32'h0, 7'd0}},
    '{CMD_DEL_VAL,   32'h0000_0000, 6'd0,  1'b1, '{ST_EMPTY,    32'h0, 7'd0}},
    '{CMD_SPARE_A,   32'hffff_ffff, 6'd63, 1'b1, '{ST_OK,       32'h0, 7'd0}},
    '{CMD_SPARE_B,   32'h8000_0000, 6'd0,  1'b1, '{ST_OK,       32'h0, 7'd0}},
    '{CMD_SPARE_C,   32'h7fff_ffff, 6'd31, 1'b1, '{ST_OK,       32'h0, 7'd0}},
    '{CMD_APPEND,    32'h8000_0000, 6'd63, 1'b1, '{ST_OK,       32'h0, 7'd1}},
    '{CMD_APPEND,    32'h7fff_ffff, 6'd0,  1'b1, '{ST_OK,       32'h0, 7'd2}},
    '{CMD_APPEND,    32'hffff_ffff, 6'd0,  1'b1, '{ST_OK,       32'h0, 7'd3}},
    '{CMD_APPEND,    32'h0000_0000, 6'd0,  1'b1, '{ST_OK,       32'h0, 7'd4}},
    '{CMD_APPEND,    32'h8000_0000, 6'd0,  1'b1, '{ST_OK,       32'h0, 7'd5}},
    '{CMD_DEL_POS,   32'h0000_0000, 6'd5,  1'b1, '{ST_RANGE,    32'h0, 7'd5}},
    '{CMD_DEL_POS,   32'hffff_ffff, 6'd63, 1'b1, '{ST_RANGE,    32'h0, 7'd5}},
    '{CMD_DEL_VAL,   32'h0000_0001, 6'd0,  1'b1, '{ST_NOTFOUND, 32'h0, 7'd5}},
    '{CMD_SPARE_C,   32'hffff_ffff, 6'd63, 1'b1, '{ST_OK,       32'h0, 7'd5}},
    '{CMD_DEL_VAL,   32'h8000_0000, 6'd0,  1'b0, '0},
    '{CMD_DEL_POS,   32'h0000_0000, 6'd1,  1'b0, '0},
    '{CMD_DEL_FIRST, 32'h0000_0000, 6'd0,  1'b0, '0},
    '{CMD_DEL_LAST,  32'h0000_0000, 6'd0,  1'b0, '0},
    '{CMD_DEL_POS,   32'h0000_0000, 6'd0,  1'b0, '0},
    '{CMD_DEL_LAST,  32'h0000_0000, 6'd0,  1'b1, '{ST_EMPTY,    32'h0, 7'd0}}
  };

  logic clk = 1'b0;
  logic rst;

  pade_req_if req ();
  pade_rsp_if rsp ();

  packed_array_delete_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  logic [WORD_W-1:0] shadow_words[$];
  outcome_t          pending_outcomes[$];
  int                mismatch_count = 0;
  int                results_seen = 0;
  int                commands_sent = 0;
  int                stall_cycles = 0;
  bit                calm = 1'b0;

  function automatic outcome_t apply_command(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] val,
                                             logic [POS_W-1:0] pos);
    outcome_t o;
    int       idx;
    o = '0;
    o.status = ST_OK;
    idx = -1;
    case (cmd)
      CMD_APPEND: begin
        if (shadow_words.size() >= DEPTH) o.status = ST_FULL;
        else shadow_words.push_back(val);
      end
      CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_POS, CMD_DEL_VAL: begin
        if (shadow_words.size() == 0) begin
          o.status = ST_EMPTY;
        end else begin
          case (cmd)
            CMD_DEL_FIRST: idx = 0;
            CMD_DEL_LAST: idx = shadow_words.size() - 1;
            CMD_DEL_POS: begin
              if (pos >= shadow_words.size()) o.status = ST_RANGE;
              else idx = int'(pos);
            end
            default: begin
              for (int k = 0; k < shadow_words.size(); k++) begin
                if (idx < 0 && shadow_words[k] == val) idx = k;
              end
              if (idx < 0) o.status = ST_NOTFOUND;
            end
          endcase
          if (idx >= 0) begin
            o.removed = shadow_words[idx];
            shadow_words.delete(idx);
          end
        end
      end
      default: ;
    endcase
    o.count = COUNT_W'(shadow_words.size());
    return o;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 3))
      0: begin
        if (shadow_words.size() != 0)
          return shadow_words[$urandom_range(0, shadow_words.size() - 1)];
        return $urandom();
      end
      1: return $urandom_range(0, 4) - 2;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    $display("%0t: result %0d %s: got %0h, expected %0h", $time, results_seen, field, got, want);
    mismatch_count++;
  endtask

  task automatic issue_command(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] val,
                               logic [POS_W-1:0] pos, bit use_typed, outcome_t typed);
    outcome_t predicted;
    predicted = apply_command(cmd, val, pos);
    if (use_typed) pending_outcomes.push_back(typed);
    else pending_outcomes.push_back(predicted);
    if (!calm) begin
      while ($urandom_range(0, 99) < 31) begin
        req.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req.valid    <= 1'b1;
    req.command  <= cmd;
    req.value    <= val;
    req.position <= pos;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    commands_sent++;
  endtask

  initial begin : command_source
    int                append_share;
    int                span;
    int                pick;
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] val;
    logic [POS_W-1:0]  pos;
    rst          = 1'b1;
    req.valid    = 1'b0;
    req.command  = '0;
    req.value    = '0;
    req.position = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue_command(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].pos,
                    directed_rows[i].typed, directed_rows[i].want);

    // fill to the brim, push past it, remove at the top index, then delete by the value of the last entry
    while (shadow_words.size() < DEPTH)
      issue_command(CMD_APPEND, pick_word(), POS_W'($urandom()), 1'b0, '0);
    repeat (3) issue_command(CMD_APPEND, $urandom(), POS_W'($urandom()), 1'b0, '0);
    issue_command(CMD_DEL_POS, $urandom(), 6'd63, 1'b0, '0);
    issue_command(CMD_DEL_VAL, shadow_words[DEPTH - 2], POS_W'($urandom()), 1'b0, '0);

    while (commands_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      append_share = $urandom_range(15, 85);
      span = $urandom_range(20, 120);
      repeat (span) begin
        calm = commands_sent >= CALM_FROM && commands_sent < CALM_TO;
        pick = $urandom_range(0, 99);
        pos = POS_W'($urandom());
        val = $urandom();
        if (pick < 4) begin
          case ($urandom_range(0, 2))
            0: cmd = CMD_SPARE_A;
            1: cmd = CMD_SPARE_B;
            default: cmd = CMD_SPARE_C;
          endcase
        end else if ($urandom_range(0, 99) < append_share) begin
          cmd = CMD_APPEND;
          val = pick_word();
        end else begin
          case ($urandom_range(0, 3))
            0: cmd = CMD_DEL_FIRST;
            1: cmd = CMD_DEL_LAST;
            2: cmd = CMD_DEL_POS;
            default: cmd = CMD_DEL_VAL;
          endcase
          if (cmd == CMD_DEL_POS && shadow_words.size() != 0 && $urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(0, shadow_words.size() - 1));
          if (cmd == CMD_DEL_VAL && shadow_words.size() != 0 && $urandom_range(0, 99) < 70)
            val = shadow_words[$urandom_range(0, shadow_words.size() - 1)];
          else if (cmd == CMD_DEL_VAL)
            val = pick_word();
        end
        issue_command(cmd, val, pos, 1'b0, '0);
      end
    end
    calm = 1'b0;
    req.valid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // long hold-off after a few hundred results so the engine backs up
  initial begin : result_sink
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) taken++;
      if (!held && taken >= HOLD_AFTER) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp.ready <= calm || ($urandom_range(0, 99) >= 31);
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected transfer, count", WORD_W'(rsp.entry_count), '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", WORD_W'(rsp.status), WORD_W'(want.status));
        if (rsp.removed_word !== want.removed)
          report_mismatch("removed_word", rsp.removed_word, want.removed);
        if (rsp.entry_count !== want.count)
          report_mismatch("entry_count", WORD_W'(rsp.entry_count), WORD_W'(want.count));
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
